// ===== rtl/distance_vector_route_update_core_macros.svh =====
// Assertion macros for the distance vector route update core.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define DVRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`define DVRU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`else
`define DVRU_ASSERT_NEXT(label, clk, rst, ante, cons)
`define DVRU_ASSERT_NOW(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/dvru_pkg.sv =====
// Types and constants shared by the route update core and its table cells.
`default_nettype none
package dvru_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int ADDR_W = 32;
   localparam int COST_W = 16;
   localparam int SLOT_W = 6;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef enum logic [1:0] {
      ACT_SAME    = 2'd0,
      ACT_UPDATED = 2'd1,
      ACT_ADDED   = 2'd2,
      ACT_DROPPED = 2'd3
   } action_type;

   typedef struct packed {
      logic [ADDR_W-1:0] dest_addr;
      logic [COST_W-1:0] adv_cost;
      logic [COST_W-1:0] link_cost;
      logic [ADDR_W-1:0] neighbor_addr;
      logic [ADDR_W-1:0] iface_addr;
   } req_item_type;

   typedef struct packed {
      action_type        action;
      logic [SLOT_W-1:0] slot;
      logic [COST_W-1:0] route_cost;
      logic [ADDR_W-1:0] route_next_hop;
   } rsp_item_type;

   // Item in flight along the cell chain.
   typedef struct packed {
      logic              valid;
      logic              done;
      logic [ADDR_W-1:0] dest;
      logic [COST_W-1:0] cand;
      logic [ADDR_W-1:0] nbr;
      logic [ADDR_W-1:0] ifc;
      rsp_item_type      result;
   } token_type;

endpackage
`default_nettype wire

// ===== rtl/dvru_cell.sv =====
// One route table cell: holds one entry and matches, updates or adds for a passing item.
`default_nettype none
`include "distance_vector_route_update_core_macros.svh"
module dvru_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire dvru_pkg::token_type in_tok,
   output dvru_pkg::token_type      out_tok
);

   localparam logic [dvru_pkg::SLOT_W-1:0] SLOT = dvru_pkg::SLOT_W'(INDEX);

   logic                          valid_ff, valid_in;
   logic [dvru_pkg::ADDR_W-1:0]   dest_ff, dest_in;
   logic [dvru_pkg::COST_W-1:0]   cost_ff, cost_in;
   logic [dvru_pkg::ADDR_W-1:0]   hop_ff, hop_in;
   logic [dvru_pkg::ADDR_W-1:0]   iface_ff, iface_in;
   dvru_pkg::token_type           tok_ff, tok_in;

   always_comb begin
      tok_in   = in_tok;
      valid_in = valid_ff;
      dest_in  = dest_ff;
      cost_in  = cost_ff;
      hop_in   = hop_ff;
      iface_in = iface_ff;
      if (in_tok.valid && !in_tok.done) begin
         if (valid_ff && (dest_ff == in_tok.dest)) begin
            tok_in.done        = 1'b1;
            tok_in.result.slot = SLOT;
            if (cost_ff > in_tok.cand) begin
               cost_in  = in_tok.cand;
               hop_in   = in_tok.nbr;
               iface_in = in_tok.ifc;
               tok_in.result.action         = dvru_pkg::ACT_UPDATED;
               tok_in.result.route_cost     = in_tok.cand;
               tok_in.result.route_next_hop = in_tok.nbr;
            end else begin
               tok_in.result.action         = dvru_pkg::ACT_SAME;
               tok_in.result.route_cost     = cost_ff;
               tok_in.result.route_next_hop = hop_ff;
            end
         end else if (!valid_ff) begin
            // first free cell: the table fills in slot order
            valid_in = 1'b1;
            dest_in  = in_tok.dest;
            cost_in  = in_tok.cand;
            hop_in   = in_tok.nbr;
            iface_in = in_tok.ifc;
            tok_in.done                  = 1'b1;
            tok_in.result.slot           = SLOT;
            tok_in.result.action         = dvru_pkg::ACT_ADDED;
            tok_in.result.route_cost     = in_tok.cand;
            tok_in.result.route_next_hop = in_tok.nbr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dest_ff       <= dest_in;
         cost_ff       <= cost_in;
         hop_ff        <= hop_in;
         iface_ff      <= iface_in;
         tok_ff.done   <= tok_in.done;
         tok_ff.dest   <= tok_in.dest;
         tok_ff.cand   <= tok_in.cand;
         tok_ff.nbr    <= tok_in.nbr;
         tok_ff.ifc    <= tok_in.ifc;
         tok_ff.result <= tok_in.result;
      end
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         tok_ff.valid <= tok_in.valid;
      end
   end

   assign out_tok = tok_ff;

   `DVRU_ASSERT_NEXT(a_entry_sticky, clock, reset, valid_ff, valid_ff)
   `DVRU_ASSERT_NEXT(a_done_passes, clock, reset,
      advance && in_tok.valid && in_tok.done, tok_ff.valid && tok_ff.done)
   `DVRU_ASSERT_NEXT(a_free_cell_takes_add, clock, reset,
      advance && in_tok.valid && !in_tok.done && !valid_ff,
      valid_ff && tok_ff.done && (tok_ff.result.action == dvru_pkg::ACT_ADDED))

endmodule
`default_nettype wire

// ===== rtl/distance_vector_route_update_core.sv =====
// Top level of the distance vector route update core: cell chain and result register.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_ready  req_item (dvru_pkg::req_item_type)
//   rsp      out  rsp_valid / rsp_ready  rsp_item (dvru_pkg::rsp_item_type)
//
// An item walks the cell chain one cell per cycle while the chain advances; its result
// passes through ENTRIES cell stages plus the result register after the accepting edge.
// Items follow each other cell by cell, so one item per cycle is sustained while
// rsp_ready holds; each cell sees earlier items' writes before later items arrive.
// Synchronous reset empties the table (valid bits only) and the chain.
// A stalled result freezes the whole chain and drops req_ready.
`default_nettype none
module distance_vector_route_update_core #(
   parameter int ENTRIES = dvru_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire dvru_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output dvru_pkg::rsp_item_type      rsp_item
);

   dvru_pkg::token_type          tok [0:ENTRIES];
   logic                         advance;
   logic [dvru_pkg::COST_W:0]    sum;
   logic                         rsp_valid_ff, rsp_valid_in;
   dvru_pkg::rsp_item_type       rsp_item_ff, rsp_item_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign sum = {1'b0, req_item.adv_cost} + {1'b0, req_item.link_cost};

   always_comb begin
      tok[0].valid  = req_valid;
      tok[0].done   = 1'b0;
      tok[0].dest   = req_item.dest_addr;
      tok[0].cand   = sum[dvru_pkg::COST_W] ? dvru_pkg::COST_MAX
                                            : sum[dvru_pkg::COST_W-1:0];
      tok[0].nbr    = req_item.neighbor_addr;
      tok[0].ifc    = req_item.iface_addr;
      tok[0].result = '0;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      dvru_cell #(
         .INDEX(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .in_tok (tok[i]),
         .out_tok(tok[i+1])
      );
   end

   always_comb begin
      rsp_valid_in = tok[ENTRIES].valid;
      rsp_item_in  = tok[ENTRIES].result;
      if (!tok[ENTRIES].done) begin
         rsp_item_in                = '0;
         rsp_item_in.action         = dvru_pkg::ACT_DROPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

// ===== tb/sv/distance_vector_route_update_core_tb.sv =====
// Testbench for the distance vector route update core: items checked against a table model.
`timescale 1ns / 1ps
`default_nettype none
module distance_vector_route_update_core_tb;

   localparam int ENTRIES      = dvru_pkg::ENTRIES_DEFAULT;
   localparam int ADDR_W       = dvru_pkg::ADDR_W;
   localparam int COST_W       = dvru_pkg::COST_W;
   localparam int SLOT_W       = dvru_pkg::SLOT_W;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = ENTRIES + 16;
   localparam int HOLD_CYCLES  = 400;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   dvru_pkg::req_item_type req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   dvru_pkg::rsp_item_type rsp_item;

   distance_vector_route_update_core #(.ENTRIES(ENTRIES)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // predicted route table
   bit                route_used [ENTRIES];
   logic [ADDR_W-1:0] route_dest [ENTRIES];
   logic [COST_W-1:0] route_cost [ENTRIES];
   logic [ADDR_W-1:0] route_hop  [ENTRIES];
   logic [ADDR_W-1:0] route_iface[ENTRIES];
   int                routes_held = 0;

   dvru_pkg::req_item_type pending_routes[$];
   dvru_pkg::rsp_item_type expected_routes[$];
   logic [ADDR_W-1:0]      known_dests[$];

   int   accepted_items = 0;
   int   total_items    = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   logic req_taken      = 1'b0;
   logic rsp_hold       = 1'b0;
   int   send_idle_pct;
   int   recv_idle_pct;

   always_comb begin
      if (accepted_items < 280) begin
         send_idle_pct = 15;
         recv_idle_pct = 78;
      end else if (accepted_items < 560) begin
         send_idle_pct = 78;
         recv_idle_pct = 15;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h (item result %0d)",
               what, got, want, accepted_items);
      mismatches++;
   endtask

   task automatic update_route_table(input dvru_pkg::req_item_type it,
                                     output dvru_pkg::rsp_item_type r);
      logic [COST_W:0]   sum;
      logic [COST_W-1:0] cand;
      int                hit;
      sum  = {1'b0, it.adv_cost} + {1'b0, it.link_cost};
      cand = sum[COST_W] ? dvru_pkg::COST_MAX : sum[COST_W-1:0];
      hit  = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && route_used[i] && route_dest[i] == it.dest_addr) hit = i;
      end
      r = '0;
      if (hit >= 0) begin
         if (route_cost[hit] > cand) begin
            route_cost[hit]  = cand;
            route_hop[hit]   = it.neighbor_addr;
            route_iface[hit] = it.iface_addr;
            r.action = dvru_pkg::ACT_UPDATED;
         end else begin
            r.action = dvru_pkg::ACT_SAME;
         end
         r.slot           = hit[SLOT_W-1:0];
         r.route_cost     = route_cost[hit];
         r.route_next_hop = route_hop[hit];
      end else if (routes_held < ENTRIES) begin
         route_used[routes_held]  = 1'b1;
         route_dest[routes_held]  = it.dest_addr;
         route_cost[routes_held]  = cand;
         route_hop[routes_held]   = it.neighbor_addr;
         route_iface[routes_held] = it.iface_addr;
         r.action         = dvru_pkg::ACT_ADDED;
         r.slot           = routes_held[SLOT_W-1:0];
         r.route_cost     = cand;
         r.route_next_hop = it.neighbor_addr;
         routes_held++;
      end else begin
         r.action = dvru_pkg::ACT_DROPPED;
      end
   endtask

   task automatic queue_route(input logic [ADDR_W-1:0] dest, input logic [COST_W-1:0] adv,
                              input logic [COST_W-1:0] link, input logic [ADDR_W-1:0] nbr,
                              input logic [ADDR_W-1:0] ifc);
      dvru_pkg::req_item_type it;
      bit                     seen;
      seen = 1'b0;
      foreach (known_dests[k]) if (known_dests[k] == dest) seen = 1'b1;
      if (!seen) known_dests = {known_dests, dest};
      it.dest_addr     = dest;
      it.adv_cost      = adv;
      it.link_cost     = link;
      it.neighbor_addr = nbr;
      it.iface_addr    = ifc;
      pending_routes = {pending_routes, it};
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_routes.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_item  <= pending_routes.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      rsp_ready <= !reset && !rsp_hold && ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // long receiver hold-off so the chain fills and back-pressures the input
   initial begin
      wait (accepted_items >= 620);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // monitor and scoreboard
   always @(posedge clock) begin : monitor
      dvru_pkg::rsp_item_type want;
      cycle_count++;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         update_route_table(req_item, want);
         expected_routes = {expected_routes, want};
         accepted_items++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_routes.size() == 0) begin
            report_mismatch("unexpected item", rsp_item.route_next_hop, '0);
         end else begin
            want = expected_routes.pop_front();
            if (rsp_item.action !== want.action)
               report_mismatch("action", 32'(rsp_item.action), 32'(want.action));
            if (rsp_item.slot !== want.slot)
               report_mismatch("slot", 32'(rsp_item.slot), 32'(want.slot));
            if (rsp_item.route_cost !== want.route_cost)
               report_mismatch("route_cost", 32'(rsp_item.route_cost),
                               32'(want.route_cost));
            if (rsp_item.route_next_hop !== want.route_next_hop)
               report_mismatch("route_next_hop", rsp_item.route_next_hop,
                               want.route_next_hop);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** distance_vector_route_update_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] dest;
      logic [COST_W-1:0] adv;
      logic [COST_W-1:0] link;
      int                mode;

      // zero and all-ones addresses, saturation, equal cost, update, worse cost
      queue_route(32'h0000_0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_route(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_route(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 32'h1111_1111, 32'h2222_2222);
      queue_route(32'hFFFF_FFFF, 16'hFFFE, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_route(32'hFFFF_FFFF, 16'h8000, 16'h8000, 32'h3333_3333, 32'h4444_4444);
      queue_route(32'h0000_0000, 16'h0000, 16'h0000, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_route(32'hA5A5_A5A5, 16'h0001, 16'hFFFF, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_route(32'hA5A5_A5A5, 16'h7FFF, 16'h8000, 32'h6666_6666, 32'h7777_7777);
      queue_route(32'hA5A5_A5A5, 16'h0010, 16'h0020, 32'h8888_8888, 32'h9999_9999);
      queue_route(32'h5A5A_5A5A, 16'hFFFF, 16'h0000, 32'hDEAD_BEEF, 32'hFEED_F00D);
      queue_route(32'h5A5A_5A5A, 16'h0000, 16'hFFFF, 32'h0123_4567, 32'h89AB_CDEF);
      queue_route(32'h5A5A_5A5A, 16'h0001, 16'h0001, 32'hFEDC_BA98, 32'h7654_3210);
      queue_route(32'h5A5A_5A5A, 16'h0005, 16'h0005, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
      queue_route(32'h8000_0001, 16'h5555, 16'hAAAA, 32'h8000_0000, 32'h0000_0001);
      queue_route(32'h8000_0001, 16'hAAAA, 16'h5554, 32'h7FFF_FFFF, 32'hFFFF_FFFE);

      // mostly re-advertised known routes; new destinations fill the table and then drop
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (known_dests.size() == 0 || $urandom_range(99, 0) < 12)
            dest = $urandom;
         else
            dest = known_dests[$urandom_range(known_dests.size() - 1, 0)];
         mode = int'($urandom_range(9, 0));
         if (mode < 6) begin
            adv  = 16'($urandom_range(3000, 0));
            link = 16'($urandom_range(300, 0));
         end else if (mode < 8) begin
            adv  = 16'($urandom);
            link = 16'($urandom);
         end else if (mode == 8) begin
            adv  = 16'($urandom_range(65535, 40000));
            link = 16'($urandom_range(65535, 40000));
         end else begin
            adv  = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
            link = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
         end
         queue_route(dest, adv, link, $urandom, $urandom);
      end
      total_items = pending_routes.size();

      wait (!reset);
      wait (accepted_items == total_items && expected_routes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_routes.size() == 0) begin
         $display("** distance_vector_route_update_core: PASSED **");
      end else begin
         $display("** distance_vector_route_update_core: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/dvru_pkg.sv
rtl/dvru_cell.sv
rtl/distance_vector_route_update_core.sv
tb/sv/distance_vector_route_update_core_tb.sv
